/* hw/rtl/decision_tree_inference_unit_macros.svh */
// Assertion helpers for the decision tree inference unit.
// Each macro expects clk and arst_n in scope.
`ifndef DECISION_TREE_INFERENCE_UNIT_MACROS_SVH
`define DECISION_TREE_INFERENCE_UNIT_MACROS_SVH

// same-cycle implication
`define DTI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DTI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/dti_pkg.sv */
package dti_pkg;

	localparam int NODE_COUNT    = 256;
	localparam int FEATURE_COUNT = 64;
	localparam int MAX_STEPS     = 32;
	localparam int VALUE_W       = 32;
	localparam int NODE_AW       = 8;
	localparam int FEAT_AW       = 6;
	localparam int CLASS_W       = 4;
	localparam int STEP_W        = 6;

	// func codes
	localparam logic FUNC_NODE    = 1'b0;
	localparam logic FUNC_FEATURE = 1'b1;

	typedef struct packed {
		logic                      func;
		logic [NODE_AW-1:0]        node_index;
		logic                      node_is_leaf;
		logic [FEAT_AW-1:0]        node_feature;
		logic signed [VALUE_W-1:0] node_threshold;
		logic [NODE_AW-1:0]        node_left;
		logic [NODE_AW-1:0]        node_right;
		logic [CLASS_W-1:0]        node_class;
		logic [FEAT_AW-1:0]        feature_index;
		logic signed [VALUE_W-1:0] feat_value;
		logic                      last_feature;
	} in_word_t;

	typedef struct packed {
		logic [CLASS_W-1:0] leaf_class;
		logic               fault;
		logic [STEP_W-1:0]  steps_taken;
	} out_word_t;

	// one node table entry
	typedef struct packed {
		logic                      is_leaf;
		logic [FEAT_AW-1:0]        feature;
		logic signed [VALUE_W-1:0] threshold;
		logic [NODE_AW-1:0]        left;
		logic [NODE_AW-1:0]        right;
		logic [CLASS_W-1:0]        cls;
	} node_t;

endpackage

/* hw/rtl/dti_ram.sv */
module dti_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/decision_tree_inference_unit.sv */
// Decision tree inference unit.
// Input channel (in_valid/in_ready/in_word): each word either writes one node
// table entry (func = node) or one feature value of the row (func = feature).
// Loads produce no result.
// A feature word with last_feature set also starts a walk from node 0. The
// walk runs on a small sequencer around one signed comparator: per internal
// node one node table read (FETCH), one feature row read (EVAL) and one
// compare (CMP). The walk ends at a leaf, or with a fault when the step
// limit of MAX_STEPS internal nodes is reached. in_ready is low for the whole
// walk and returns in the same cycle in which the result word appears in the
// output register.
// Output channel (out_valid/out_ready/out_word): one word per walk. A stalled
// receiver only holds the output register; loads are still taken meanwhile,
// and a following walk waits at its end until the register is free.
// Reset clears the sequencer and output valid. Table and row memories are
// not cleared; an entry must be written before a walk reads it.
module decision_tree_inference_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  dti_pkg::in_word_t  in_word,
	output logic               out_valid,
	input  logic               out_ready,
	output dti_pkg::out_word_t out_word
);

	import dti_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_FETCH = 5'b00010,
		S_EVAL  = 5'b00100,
		S_CMP   = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t state_q;

	logic [NODE_AW-1:0] cur_node_q;
	logic [STEP_W-1:0]  steps_q;
	logic [CLASS_W-1:0] res_cls_q;
	logic               res_fault_q;
	logic               out_valid_q;
	out_word_t          out_q;

	logic               in_acc;
	logic               node_we;
	logic               feat_we;
	logic               walk_start;
	logic               out_load;
	logic               go_left;
	node_t              node_wdata;
	node_t              node_rd;
	logic [VALUE_W-1:0] feat_rd;

	assign in_ready   = (state_q == S_IDLE);
	assign in_acc     = in_valid && in_ready;
	assign node_we    = in_acc && (in_word.func == FUNC_NODE);
	assign feat_we    = in_acc && (in_word.func == FUNC_FEATURE);
	assign walk_start = feat_we && in_word.last_feature;

	assign node_wdata = '{
		is_leaf:   in_word.node_is_leaf,
		feature:   in_word.node_feature,
		threshold: in_word.node_threshold,
		left:      in_word.node_left,
		right:     in_word.node_right,
		cls:       in_word.node_class
	};

	// node table: read address follows the current node, read data is registered
	dti_ram #(
		.WIDTH($bits(node_t)),
		.DEPTH(NODE_COUNT)
	) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (in_word.node_index),
		.wdata (node_wdata),
		.raddr (cur_node_q),
		.rdata (node_rd)
	);

	// feature row: addressed by the feature number of the node just read
	dti_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(FEATURE_COUNT)
	) u_feat_ram (
		.clk   (clk),
		.we    (feat_we),
		.waddr (in_word.feature_index),
		.wdata (in_word.feat_value),
		.raddr (node_rd.feature),
		.rdata (feat_rd)
	);

	// the shared comparator: feature <= threshold takes the left child
	assign go_left  = ($signed(feat_rd) <= node_rd.threshold);
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// walk sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cur_node_q <= '0;
			steps_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (walk_start) begin
						cur_node_q <= '0;
						steps_q    <= '0;
						state_q    <= S_FETCH;
					end
				end
				S_FETCH: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					// leaf ends the walk; else the step limit; else compare next
					if (node_rd.is_leaf || (steps_q >= STEP_W'(MAX_STEPS))) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					cur_node_q <= go_left ? node_rd.left : node_rd.right;
					steps_q    <= steps_q + 1'b1;
					state_q    <= S_FETCH;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// walk outcome, taken in every EVAL state; the last one stands when the walk ends
	always_ff @(posedge clk) begin
		if (state_q == S_EVAL) begin
			res_cls_q   <= node_rd.is_leaf ? node_rd.cls : '0;
			res_fault_q <= !node_rd.is_leaf;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.leaf_class  <= res_cls_q;
			out_q.fault       <= res_fault_q;
			out_q.steps_taken <= steps_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

/* hw/rtl/dti_checker.sv */
`include "decision_tree_inference_unit_macros.svh"

module dti_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input dti_pkg::in_word_t  in_word,
	input logic               out_valid,
	input logic               out_ready,
	input dti_pkg::out_word_t out_word
);

	import dti_pkg::*;

	localparam logic [STEP_W-1:0] STEP_LIMIT = STEP_W'(MAX_STEPS);

	logic out_stall;
	logic fault_seen;
	logic walk_go;

	assign out_stall  = out_valid && !out_ready;
	assign fault_seen = out_valid && out_word.fault;
	assign walk_go    = in_valid && in_ready && (in_word.func == FUNC_FEATURE)
		&& in_word.last_feature;

	`DTI_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_word), "stalled word changed")
	`DTI_ASSERT_NOW(a_fault_class, fault_seen, out_word.leaf_class == '0, "fault with a class")
	`DTI_ASSERT_NOW(a_fault_steps, fault_seen, out_word.steps_taken == STEP_LIMIT, "early fault")
	`DTI_ASSERT_NOW(a_steps_max, out_valid, out_word.steps_taken <= STEP_LIMIT, "steps over limit")
	`DTI_ASSERT_NEXT(a_walk_busy, walk_go, !in_ready, "input taken during a walk")

endmodule

bind decision_tree_inference_unit dti_checker u_dti_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_word   (in_word),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_word  (out_word)
);

/* bench/tree_walk_checker.sv */
// Watches both channels of the decision tree unit, keeps a copy of the node
// table and feature row, and checks every result word against its own walk.
module tree_walk_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  dti_pkg::in_word_t  in_word,
	input  logic               out_valid,
	input  logic               out_ready,
	input  dti_pkg::out_word_t out_word,
	output int                 fail_count,
	output int                 open_count
);
	import dti_pkg::*;

	node_t                     tree_nodes [NODE_COUNT];
	logic signed [VALUE_W-1:0] row_values [FEATURE_COUNT];
	out_word_t                 pending_walks [$];

	// walk from node 0 over the current table and row
	function automatic out_word_t walk_tree();
		out_word_t          res;
		node_t              nd;
		logic [NODE_AW-1:0] at;
		int unsigned        passed;
		bit                 done;
		res = '0;
		at = '0;
		passed = 0;
		done = 1'b0;
		while (!done) begin
			nd = tree_nodes[at];
			if (nd.is_leaf) begin
				res.leaf_class = nd.cls;
				done = 1'b1;
			end else if (passed >= MAX_STEPS) begin
				res.fault = 1'b1;
				done = 1'b1;
			end else begin
				// ties go left
				if ($signed(row_values[nd.feature]) <= $signed(nd.threshold))
					at = nd.left;
				else
					at = nd.right;
				passed++;
			end
		end
		res.steps_taken = STEP_W'(passed);
		return res;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		out_word_t want;
		if (!arst_n) begin
			fail_count = 0;
			open_count = 0;
		end else begin
			if (in_valid && in_ready) begin
				if (in_word.func == FUNC_NODE) begin
					tree_nodes[in_word.node_index] = '{
						is_leaf:   in_word.node_is_leaf,
						feature:   in_word.node_feature,
						threshold: in_word.node_threshold,
						left:      in_word.node_left,
						right:     in_word.node_right,
						cls:       in_word.node_class
					};
				end else begin
					row_values[in_word.feature_index] = in_word.feat_value;
					if (in_word.last_feature)
						pending_walks.insert(pending_walks.size(), walk_tree());
				end
			end
			if (out_valid && out_ready) begin
				if (pending_walks.size() == 0) begin
					$error("unexpected result word: class %0d fault %0d steps %0d",
						out_word.leaf_class, out_word.fault, out_word.steps_taken);
					fail_count++;
				end else begin
					want = pending_walks.pop_front();
					check_field("leaf_class", want.leaf_class, out_word.leaf_class);
					check_field("fault", want.fault, out_word.fault);
					check_field("steps_taken", want.steps_taken, out_word.steps_taken);
				end
			end
			open_count = pending_walks.size();
		end
	end

endmodule

/* bench/decision_tree_inference_unit_tb.sv */
// Top of the decision tree unit bench: clock, reset, word stimulus with
// random gaps, a randomly stalling receiver, and the final verdict. All
// prediction and comparison lives in tree_walk_checker.
module decision_tree_inference_unit_tb;
	import dti_pkg::*;

	localparam int unsigned ITEM_TARGET = 1450;
	// margin over the longest walk, including a stalled output register
	localparam int unsigned SETTLE_CYCLES = 150;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_word_t  in_word;
	logic      out_valid;
	logic      out_ready;
	out_word_t out_word;
	int        fail_count;
	int        open_count;

	int unsigned words_sent;
	int unsigned sender_calm;   // words left in a no-gap stretch
	int unsigned receiver_calm; // cycles left in a no-stall stretch
	int unsigned stall_left;

	decision_tree_inference_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	tree_walk_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_word    (in_word),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_word   (out_word),
		.fail_count (fail_count),
		.open_count (open_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop; far beyond the slowest legal run
	initial begin
		#4000000;
		$display("decision_tree_inference_unit_tb failed");
		$finish;
	end

	// Gap before each word: mostly none or short, a few long, and now and
	// then a long stretch with no gaps at all.
	function automatic int unsigned sender_gap();
		int unsigned r;
		if (sender_calm > 0) begin
			sender_calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2)
			sender_calm = $urandom_range(20, 100);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic int unsigned receiver_stall();
		int unsigned r;
		if (receiver_calm > 0) begin
			receiver_calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2)
			receiver_calm = $urandom_range(50, 300);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		if (r < 99)
			return $urandom_range(4, 20);
		return $urandom_range(40, 100);
	endfunction

	// Q16.16 values: extremes, zero, all ones (the smallest negative step), small numbers around the origin
	// (so splits go both ways), or anything at all.
	function automatic logic [VALUE_W-1:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 9);
		case (r)
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '0;
			3: return '1;
			4, 5, 6: return VALUE_W'($urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000);
			default: return VALUE_W'($urandom);
		endcase
	endfunction

	// most trees test a handful of features so that row rewrites matter
	function automatic logic [FEAT_AW-1:0] pick_feature();
		if ($urandom_range(0, 3) != 0)
			return FEAT_AW'($urandom_range(0, 7));
		return FEAT_AW'($urandom);
	endfunction

	// Unused fields of a word carry random bits.
	function automatic in_word_t noisy_word();
		logic [127:0] junk;
		junk = {$urandom, $urandom, $urandom, $urandom};
		return junk[$bits(in_word_t)-1:0];
	endfunction

	function automatic in_word_t node_word(logic [NODE_AW-1:0] idx, logic leaf,
		logic [FEAT_AW-1:0] feat, logic [VALUE_W-1:0] thr, logic [NODE_AW-1:0] lt,
		logic [NODE_AW-1:0] rt, logic [CLASS_W-1:0] cls);
		in_word_t w;
		w = noisy_word();
		w.func = FUNC_NODE;
		w.node_index = idx;
		w.node_is_leaf = leaf;
		w.node_feature = feat;
		w.node_threshold = thr;
		w.node_left = lt;
		w.node_right = rt;
		w.node_class = cls;
		return w;
	endfunction

	function automatic in_word_t feature_word(logic [FEAT_AW-1:0] idx,
		logic [VALUE_W-1:0] value, logic last);
		in_word_t w;
		w = noisy_word();
		w.func = FUNC_FEATURE;
		w.feature_index = idx;
		w.feat_value = value;
		w.last_feature = last;
		return w;
	endfunction

	// Present one word after a gap and hold it until accepted. Valid stays
	// high afterwards; the next call or drain_walks replaces or drops it at
	// the following falling edge.
	task automatic send_word(input in_word_t w);
		int unsigned gap;
		gap = sender_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_sent++;
	endtask

	// hold off the sender until every walk result has been returned
	task automatic drain_walks();
		@(negedge clk);
		in_valid <= 1'b0;
		while (open_count != 0)
			@(negedge clk);
	endtask

	// A few random feature writes, then the row-ending word.
	task automatic classify_row(input int unsigned extra);
		int unsigned k;
		for (k = 0; k < extra; k++)
			send_word(feature_word(pick_feature(), pick_value(), 1'b0));
		send_word(feature_word(pick_feature(), pick_value(), 1'b1));
	endtask

	// Receiver: stalls of random length, sometimes long, sometimes none.
	initial begin
		out_ready = 1'b0;
		stall_left = 0;
		receiver_calm = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				stall_left = receiver_stall();
			end
		end
	end

	initial begin
		in_word_t    w;
		int unsigned size;
		int unsigned k;
		int unsigned r;
		int unsigned rows;
		logic        leaf;
		logic [NODE_AW-1:0] lt;
		logic [NODE_AW-1:0] rt;

		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		words_sent = 0;
		sender_calm = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part. Every walk here only touches entries written above it.
		// Node word with last_feature set: must not start a walk.
		w = node_word(8'd0, 1'b1, 6'd63, 32'h7FFF_FFFF, 8'd255, 8'd255, 4'd15);
		w.last_feature = 1'b1;
		send_word(w);
		send_word(feature_word(6'd63, 32'h7FFF_FFFF, 1'b0));
		// root is a leaf: class 15, no steps
		send_word(feature_word(6'd0, 32'h8000_0000, 1'b1));
		send_word(node_word(8'd255, 1'b1, 6'd0, 32'h8000_0000, 8'd0, 8'd0, 4'd9));
		send_word(node_word(8'd1, 1'b1, 6'd0, '0, 8'd0, 8'd0, 4'd0));
		// root splits at the largest threshold: equal value goes left
		send_word(node_word(8'd0, 1'b0, 6'd63, 32'h7FFF_FFFF, 8'd255, 8'd1, 4'd0));
		send_word(feature_word(6'd63, 32'h7FFF_FFFF, 1'b1));
		// root splits at the smallest threshold
		send_word(node_word(8'd0, 1'b0, 6'd63, 32'h8000_0000, 8'd255, 8'd1, 4'd15));
		send_word(feature_word(6'd63, 32'h8000_0000, 1'b1));
		send_word(feature_word(6'd63, 32'h7FFF_FFFF, 1'b1));
		send_word(feature_word(6'd63, 32'hFFFF_FFFF, 1'b1));
		// node 2 loops on itself: the step limit ends the walk with a fault
		send_word(node_word(8'd2, 1'b0, 6'd0, '0, 8'd2, 8'd2, 4'd15));
		send_word(node_word(8'd0, 1'b0, 6'd0, 32'h7FFF_FFFF, 8'd2, 8'd2, 4'd7));
		send_word(feature_word(6'd0, '0, 1'b1));
		// plain row update with no walk, then one more walk with feature 0 negative
		send_word(feature_word(6'd42, 32'h0001_8000, 1'b0));
		send_word(feature_word(6'd0, 32'hFFFE_8000, 1'b1));

		drain_walks();

		// Fill the whole table and row so that any later walk reads only
		// written entries.
		for (k = 0; k < NODE_COUNT; k++)
			send_word(node_word(NODE_AW'(k), 1'($urandom), pick_feature(), pick_value(),
				NODE_AW'($urandom), NODE_AW'($urandom), CLASS_W'($urandom)));
		for (k = 0; k < FEATURE_COUNT; k++)
			send_word(feature_word(FEAT_AW'(k), pick_value(), 1'b0));
		classify_row(0);

		while (words_sent < ITEM_TARGET) begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				// acyclic tree over nodes 0..size-1, children always higher,
				// then several rows classified against it
				size = $urandom_range(1, 12);
				for (k = 0; k < size; k++) begin
					leaf = (k == size - 1) || (k != 0 && $urandom_range(0, 3) == 0);
					if (leaf) begin
						lt = NODE_AW'($urandom);
						rt = NODE_AW'($urandom);
					end else begin
						lt = NODE_AW'($urandom_range(k + 1, size - 1));
						rt = NODE_AW'($urandom_range(k + 1, size - 1));
					end
					send_word(node_word(NODE_AW'(k), leaf, pick_feature(), pick_value(),
						lt, rt, CLASS_W'($urandom)));
				end
				rows = $urandom_range(1, 4);
				for (k = 0; k < rows; k++)
					classify_row($urandom_range(0, 5));
			end else if (r < 60) begin
				// chain near the step limit: leaf right at, below or past it
				size = $urandom_range(MAX_STEPS - 4, MAX_STEPS + 4);
				for (k = 0; k < size; k++)
					send_word(node_word(NODE_AW'(k), 1'b0, pick_feature(), pick_value(),
						NODE_AW'(k + 1), NODE_AW'(k + 1), CLASS_W'($urandom)));
				send_word(node_word(NODE_AW'(size), 1'b1, pick_feature(), pick_value(),
					NODE_AW'($urandom), NODE_AW'($urandom), CLASS_W'($urandom)));
				classify_row($urandom_range(0, 2));
			end else if (r < 80) begin
				// noise: any node or feature, occasional walk on whatever is there
				size = $urandom_range(1, 10);
				for (k = 0; k < size; k++) begin
					if ($urandom_range(0, 1) == 0)
						send_word(node_word(NODE_AW'($urandom), 1'($urandom), FEAT_AW'($urandom),
							pick_value(), NODE_AW'($urandom), NODE_AW'($urandom),
							CLASS_W'($urandom)));
					else
						send_word(feature_word(FEAT_AW'($urandom), pick_value(),
							$urandom_range(0, 3) == 0));
				end
			end else begin
				classify_row($urandom_range(0, 8));
			end
			if ($urandom_range(0, 39) == 0)
				drain_walks();
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (open_count != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("decision_tree_inference_unit_tb passed");
		else
			$display("decision_tree_inference_unit_tb failed");
		$finish;
	end

endmodule
